/* src/nmr_pulse_scan_sequencer_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the NMR pulse scan sequencer
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef NMR_PULSE_SCAN_SEQUENCER_TOP_ASSERT_SVH
`define NMR_PULSE_SCAN_SEQUENCER_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define NPS_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Same-cycle implication.
`define NPS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Widths, codes and result type for the NMR pulse scan sequencer.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int unsigned OpW      = 2;
  localparam int unsigned ScanW    = 16;
  localparam int unsigned TickW    = 16;
  localparam int unsigned PulseW   = 15;
  localparam int unsigned RecW     = 15;
  localparam int unsigned PreW     = 8;
  localparam int unsigned PostW    = 8;
  localparam int unsigned SampleW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // Input operation codes; code 3 is unused.
  typedef enum logic [OpW-1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_CAPDONE = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PULSE    = 3'd0,
    REG_RECOVERY = 3'd1,
    REG_PRE      = 3'd2,
    REG_POST     = 3'd3,
    REG_SAMPLES  = 3'd4
  } reg_e;

  typedef struct packed {
    logic               coil_on;
    logic               relay_on;
    logic               capture_start;
    logic [SampleW-1:0] capture_length;
    logic               scan_advance;
    logic               buffer_clear;
    logic               busy_res;
    logic [ScanW-1:0]   scans_left;
  } result_t;

endpackage

/* src/nps_if.sv */
// ----------------------------------------------------------------------------
// nps_in_if / nps_out_if
// Valid/ready channels for sequencer events and per-event results.
// ----------------------------------------------------------------------------
interface nps_in_if import nps_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [ScanW-1:0] scan_request;

  modport source (output valid, output operation, output scan_request, input ready);
  modport sink   (input valid, input operation, input scan_request, output ready);
endinterface

interface nps_out_if import nps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               coil_on;
  logic               relay_on;
  logic               capture_start;
  logic [SampleW-1:0] capture_length;
  logic               scan_advance;
  logic               buffer_clear;
  logic               busy_res;
  logic [ScanW-1:0]   scans_left;

  modport source (
    output valid, output coil_on, output relay_on, output capture_start,
    output capture_length, output scan_advance, output buffer_clear,
    output busy_res, output scans_left, input ready
  );
  modport sink (
    input valid, input coil_on, input relay_on, input capture_start,
    input capture_length, input scan_advance, input buffer_clear,
    input busy_res, input scans_left, output ready
  );
endinterface

/* src/nmr_pulse_scan_sequencer_top.sv */
// Result: each result beat is registered and appears on out_o in the cycle after its event beat is taken.
// Throughput: one event per cycle; the phase update is one pass of logic from the
//   state registers into the result register, and in_i stalls only while a result
//   is held and out_o is not ready.
// Reset: idle phase, no scans pending, tick counter and all config registers zero,
//   no result held. No clearing pass.
// ----------------------------------------------------------------------------
// nmr_pulse_scan_sequencer_top
// Pulse-and-acquire scan sequencer running on half-millisecond tick events.
// ----------------------------------------------------------------------------
`include "nmr_pulse_scan_sequencer_top_assert.svh"

module nmr_pulse_scan_sequencer_top import nps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  nps_in_if.sink              in_i,
  nps_out_if.source           out_o
);

  // Scan phases. The end-of-scan step is transient and never stored.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COIL,
    PH_PRE,
    PH_POST,
    PH_CAP,
    PH_REC
  } phase_e;

  // Configuration registers
  logic [PulseW-1:0]  pulse_q;
  logic [RecW-1:0]    recovery_q;
  logic [PreW-1:0]    pre_q;
  logic [PostW-1:0]   post_q;
  logic [SampleW-1:0] samples_q;

  // Sequencer state
  phase_e           phase_q, phase_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic [ScanW-1:0] pend_q, pend_d;

  // Output stage
  logic    out_valid_q;
  result_t res_q, res_d;

  logic             in_acc;
  logic             timing_phase;
  logic [TickW-1:0] target;
  logic [TickW-1:0] tick_inc;
  logic             go_fwd, go_rec, go_done;
  phase_e           fwd_from, fwd;
  logic             cap_flag, adv_flag, clr_flag;

  // Output register decouples the two sides: take a new event whenever the
  // held result is gone or is leaving this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  // Timed phases count ticks up to twice the programmed milliseconds.
  assign timing_phase = (phase_q == PH_COIL) || (phase_q == PH_PRE) ||
                        (phase_q == PH_POST) || (phase_q == PH_REC);

  always_comb begin
    case (phase_q)
      PH_COIL: target = {pulse_q, 1'b0};
      PH_PRE:  target = {{(TickW-PreW-1){1'b0}}, pre_q, 1'b0};
      PH_POST: target = {{(TickW-PostW-1){1'b0}}, post_q, 1'b0};
      PH_REC:  target = {recovery_q, 1'b0};
      default: target = '0;
    endcase
  end

  assign tick_inc = tick_q + TickW'(1);

  // Next state. Zero-length phases are skipped in the same event, so one
  // event may end a scan, start the next and reach the capture request.
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    pend_d   = pend_q;
    cap_flag = 1'b0;
    adv_flag = 1'b0;
    clr_flag = 1'b0;
    go_fwd   = 1'b0;
    go_rec   = 1'b0;
    go_done  = 1'b0;
    fwd_from = PH_COIL;
    fwd      = PH_COIL;

    if (in_acc) begin
      case (in_i.operation)
        OP_TICK: begin
          if (timing_phase) begin
            tick_d = tick_inc;
            if (tick_inc >= target) begin
              case (phase_q)
                PH_COIL: begin
                  go_fwd   = 1'b1;
                  fwd_from = PH_PRE;
                end
                PH_PRE: begin
                  go_fwd   = 1'b1;
                  fwd_from = PH_POST;
                end
                PH_POST: begin
                  go_fwd   = 1'b1;
                  fwd_from = PH_CAP;
                end
                PH_REC:  go_done = 1'b1;
                default: ;
              endcase
            end
          end
        end
        OP_START: begin
          // Refused while scans are pending.
          if (pend_q == '0) begin
            clr_flag = 1'b1;
            pend_d   = in_i.scan_request;
            if (in_i.scan_request != '0) begin
              go_fwd   = 1'b1;
              fwd_from = PH_COIL;
            end else begin
              phase_d = PH_IDLE;
              tick_d  = '0;
            end
          end
        end
        OP_CAPDONE: begin
          if (phase_q == PH_CAP) go_rec = 1'b1;
        end
        default: ;
      endcase
    end

    if (go_rec) begin
      if (recovery_q != '0) begin
        phase_d = PH_REC;
        tick_d  = '0;
      end else begin
        go_done = 1'b1;
      end
    end

    // End of scan: count it down, then either run the next scan or go idle.
    if (go_done) begin
      pend_d   = pend_q - ScanW'(1);
      adv_flag = 1'b1;
      if (pend_d != '0) begin
        go_fwd   = 1'b1;
        fwd_from = PH_COIL;
      end else begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    end

    // Forward walk through coil, pre and post delays, ending at capture.
    if (go_fwd) begin
      fwd = fwd_from;
      if ((fwd == PH_COIL) && (pulse_q == '0)) fwd = PH_PRE;
      if ((fwd == PH_PRE)  && (pre_q == '0))   fwd = PH_POST;
      if ((fwd == PH_POST) && (post_q == '0))  fwd = PH_CAP;
      phase_d = fwd;
      tick_d  = '0;
      if (fwd == PH_CAP) cap_flag = 1'b1;
    end
  end

  // Result reflects levels after the event.
  always_comb begin
    res_d.coil_on        = (phase_d == PH_COIL);
    res_d.relay_on       = (phase_d == PH_POST) || (phase_d == PH_CAP);
    res_d.capture_start  = cap_flag;
    res_d.capture_length = cap_flag ? samples_q : '0;
    res_d.scan_advance   = adv_flag;
    res_d.buffer_clear   = clr_flag;
    res_d.busy_res       = (pend_d != '0);
    res_d.scans_left     = pend_d;
  end

  // Config writes are dropped while scans are pending.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_q    <= '0;
      recovery_q <= '0;
      pre_q      <= '0;
      post_q     <= '0;
      samples_q  <= '0;
    end else if (cfg_we_i && (pend_q == '0)) begin
      case (cfg_idx_i)
        REG_PULSE:    pulse_q    <= cfg_wdata_i[PulseW-1:0];
        REG_RECOVERY: recovery_q <= cfg_wdata_i[RecW-1:0];
        REG_PRE:      pre_q      <= cfg_wdata_i[PreW-1:0];
        REG_POST:     post_q     <= cfg_wdata_i[PostW-1:0];
        REG_SAMPLES:  samples_q  <= cfg_wdata_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      pend_q  <= pend_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) res_q <= res_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.coil_on        = res_q.coil_on;
  assign out_o.relay_on       = res_q.relay_on;
  assign out_o.capture_start  = res_q.capture_start;
  assign out_o.capture_length = res_q.capture_length;
  assign out_o.scan_advance   = res_q.scan_advance;
  assign out_o.buffer_clear   = res_q.buffer_clear;
  assign out_o.busy_res       = res_q.busy_res;
  assign out_o.scans_left     = res_q.scans_left;

  `NPS_ASSERT_HOLDS(a_idle_iff_no_scans, (phase_q == PH_IDLE) == (pend_q == '0), "idle phase and pending count disagree")
  `NPS_ASSERT_IMPLIES(a_tick_below_target, timing_phase, tick_q < target, "tick count reached target without leaving phase")
  `NPS_ASSERT_NEXT(a_busy_start_no_clear, in_acc && (in_i.operation == OP_START) && (pend_q != '0), !res_q.buffer_clear, "buffer clear on refused start")
  `NPS_ASSERT_NEXT(a_busy_cfg_locked, cfg_we_i && (pend_q != '0), $stable(pulse_q) && $stable(recovery_q) && $stable(pre_q) && $stable(post_q) && $stable(samples_q), "config changed while busy")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: NMR pulse scan sequencer testbench
// Drives sequencer events (ticks, starts, capture-done) through the valid/ready
// input channel and checks every result beat against an in-bench cycle-free
// model of the scan sequence. Timing registers are reprogrammed between runs
// while the sequencer is idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nps_pkg::*;

  // Operation code 3 has no enum member; the block must treat it as a no-op.
  localparam logic [OpW-1:0] OP_UNUSED  = 2'd3;
  localparam int unsigned    RunLimitNs = 30_000_000;
  // Results are registered behind their events; spare cycles follow before cfg writes.
  localparam int unsigned    QuietCycles = 4;

  // Sequencer phases as tracked by the predictor.
  typedef enum logic [2:0] {
    S_IDLE, S_COIL, S_PRE, S_POST, S_CAPTURE, S_RECOVER, S_DONE
  } seq_phase_e;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [ScanW-1:0] req;
  } seq_cmd_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  nps_in_if  in_if ();
  nps_out_if out_if ();

  nmr_pulse_scan_sequencer_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #1 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: timing registers, phase, tick counter, scans left.
  // --------------------------------------------------------------------------
  logic [PulseW-1:0]  coil_ms;
  logic [RecW-1:0]    rec_ms;
  logic [PreW-1:0]    pre_ms;
  logic [PostW-1:0]   post_ms;
  logic [SampleW-1:0] cap_len;
  seq_phase_e         seq_phase;
  logic [TickW-1:0]   tick_cnt;
  logic [ScanW-1:0]   scans_open;
  bit                 cap_req;    // capture requested during current event
  bit                 scan_done;  // scan retired during current event

  seq_cmd_t    scan_cmds[$];          // events waiting to go out on in_if
  result_t     predicted_outputs[$];  // results owed by the block, oldest first
  int unsigned mismatches = 0;

  // Phase length in ticks: two ticks per millisecond.
  function automatic logic [TickW-1:0] phase_ticks(seq_phase_e p);
    case (p)
      S_COIL:    return {coil_ms, 1'b0};
      S_PRE:     return TickW'({pre_ms, 1'b0});
      S_POST:    return TickW'({post_ms, 1'b0});
      S_RECOVER: return {rec_ms, 1'b0};
      default:   return '0;
    endcase
  endfunction

  // Walk forward from a phase; zero-length phases fall straight through, so
  // one event can retire a scan and arm the next capture.
  function automatic void enter_step(seq_phase_e first);
    seq_phase_e nxt;
    bit         settled;
    nxt     = first;
    settled = 1'b0;
    while (!settled) begin
      case (nxt)
        S_COIL, S_PRE, S_POST, S_RECOVER: begin
          if (phase_ticks(nxt) != 0) begin
            seq_phase = nxt;
            tick_cnt  = '0;
            settled   = 1'b1;
          end else begin
            nxt = (nxt == S_RECOVER) ? S_DONE : seq_phase_e'(nxt + 1);
          end
        end
        S_CAPTURE: begin
          seq_phase = S_CAPTURE;
          tick_cnt  = '0;
          cap_req   = 1'b1;
          settled   = 1'b1;
        end
        S_DONE: begin
          scans_open = scans_open - 1'b1;
          scan_done  = 1'b1;
          if (scans_open != 0) begin
            nxt = S_COIL;
          end else begin
            seq_phase = S_IDLE;
            tick_cnt  = '0;
            settled   = 1'b1;
          end
        end
        default: begin
          seq_phase = S_IDLE;
          tick_cnt  = '0;
          settled   = 1'b1;
        end
      endcase
    end
  endfunction

  // Apply one accepted event and return the result beat it must produce.
  function automatic result_t sequence_step(seq_cmd_t cmd);
    result_t res;
    bit      clr;
    clr       = 1'b0;
    cap_req   = 1'b0;
    scan_done = 1'b0;
    if (cmd.op == OP_TICK) begin
      // ticks only count in the timed phases
      if (seq_phase inside {S_COIL, S_PRE, S_POST, S_RECOVER}) begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= phase_ticks(seq_phase)) begin
          enter_step((seq_phase == S_RECOVER) ? S_DONE : seq_phase_e'(seq_phase + 1));
        end
      end
    end else if (cmd.op == OP_START) begin
      // start only taken when nothing is pending; zero scans just clears
      if (scans_open == 0) begin
        clr        = 1'b1;
        scans_open = cmd.req;
        if (cmd.req != 0) begin
          enter_step(S_COIL);
        end else begin
          seq_phase = S_IDLE;
          tick_cnt  = '0;
        end
      end
    end else if (cmd.op == OP_CAPDONE) begin
      if (seq_phase == S_CAPTURE) enter_step(S_RECOVER);
    end
    res.coil_on        = (seq_phase == S_COIL);
    res.relay_on       = (seq_phase == S_POST || seq_phase == S_CAPTURE);
    res.capture_start  = cap_req;
    res.capture_length = cap_req ? cap_len : '0;
    res.scan_advance   = scan_done;
    res.buffer_clear   = clr;
    res.busy_res       = (scans_open != 0);
    res.scans_left     = scans_open;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Well-formed next event for the current phase: start when idle, capture
  // done while capturing, tick otherwise. Unused fields carry random bits.
  function automatic seq_cmd_t next_cmd();
    seq_cmd_t cmd;
    cmd.req = ScanW'($urandom);
    case (seq_phase)
      S_IDLE: begin
        cmd.op  = OP_START;
        cmd.req = ($urandom_range(0, 7) == 0) ? '0 : ScanW'($urandom_range(1, 4));
      end
      S_CAPTURE: cmd.op = OP_CAPDONE;
      default:   cmd.op = OP_TICK;
    endcase
    return cmd;
  endfunction

  function automatic void issue(logic [OpW-1:0] op, logic [ScanW-1:0] req);
    seq_cmd_t cmd;
    cmd.op  = op;
    cmd.req = req;
    scan_cmds.push_back(cmd);
  endfunction

  // Fill bits above the register width with junk; the block must drop them.
  function automatic logic [CfgDataW-1:0] with_junk(int unsigned w, logic [CfgDataW-1:0] v);
    logic [CfgDataW-1:0] mask;
    mask = (w >= CfgDataW) ? '1 : ((CfgDataW'(1) << w) - 1'b1);
    return ($urandom & ~mask) | (v & mask);
  endfunction

  // Wait until every event is out and every result is back, then a few more.
  // Checked on the falling edge, clear of the posedge queue updates.
  task automatic settle();
    do @(negedge clk_i); while (scan_cmds.size() != 0 || predicted_outputs.size() != 0);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  // Single-cycle register write; mirrored into the predictor on the write edge.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (scans_open == 0) begin
      case (idx)
        REG_PULSE:    coil_ms = data[PulseW-1:0];
        REG_RECOVERY: rec_ms  = data[RecW-1:0];
        REG_PRE:      pre_ms  = data[PreW-1:0];
        REG_POST:     post_ms = data[PostW-1:0];
        REG_SAMPLES:  cap_len = data;
        default: ;
      endcase
    end
  endtask

  task automatic program_timing(logic [PulseW-1:0] pulse, logic [RecW-1:0] rec,
                                logic [PreW-1:0] pre, logic [PostW-1:0] post,
                                logic [SampleW-1:0] samples);
    write_reg(REG_PULSE,    with_junk(PulseW, CfgDataW'(pulse)));
    write_reg(REG_RECOVERY, with_junk(RecW, CfgDataW'(rec)));
    write_reg(REG_PRE,      with_junk(PreW, CfgDataW'(pre)));
    write_reg(REG_POST,     with_junk(PostW, CfgDataW'(post)));
    write_reg(REG_SAMPLES,  samples);
  endtask

  // Feed well-formed events until no scans are pending. Keeps at most two
  // events queued so choices follow the predicted phase closely.
  task automatic drain_scans();
    settle();
    while (scans_open != 0) begin
      @(negedge clk_i);
      if (scans_open != 0 && scan_cmds.size() < 2) scan_cmds.push_back(next_cmd());
    end
    settle();
  endtask

  task automatic run_scans(logic [ScanW-1:0] count);
    @(negedge clk_i);
    issue(OP_START, count);
    drain_scans();
  endtask

  // Mostly well-formed events with random content, about one in ten pure
  // noise. Noise starts carry a big count only when they cannot be taken.
  task automatic feed_random(int unsigned n);
    int unsigned sent;
    seq_cmd_t    cmd;
    sent = 0;
    while (sent < n) begin
      @(negedge clk_i);
      while (scan_cmds.size() < 2 && sent < n) begin
        if ($urandom_range(0, 9) == 0) begin
          cmd.op  = OpW'($urandom);
          cmd.req = ScanW'($urandom);
          if (cmd.op == OP_START && scans_open < 2) cmd.req = ScanW'($urandom_range(0, 4));
        end else begin
          cmd = next_cmd();
          sent++;
        end
        scan_cmds.push_back(cmd);
      end
    end
    drain_scans();
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them. Valid holds
  // until the beat is taken; the predictor runs on the accepting edge.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        // push the prediction before the pop so settle never sees both empty
        predicted_outputs.push_back(sequence_step(scan_cmds[0]));
        void'(scan_cmds.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else if (gap_left != 0) begin
        gap_left--;
      end
      if (gap_left == 0 && scan_cmds.size() != 0) begin
        in_if.valid        <= 1'b1;
        in_if.operation    <= scan_cmds[0].op;
        in_if.scan_request <= scan_cmds[0].req;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: ready follows a rotating stall pattern, reloaded periodically at
  // random; a third of the patterns never stall. Bit 7 is forced low so no
  // stall lasts a whole rotation of the pattern.
  // --------------------------------------------------------------------------
  logic [7:0]  stall_pat = '0;
  int unsigned pat_age   = 0;

  function automatic void check_field(string name, logic [SampleW-1:0] want,
                                      logic [SampleW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (predicted_outputs.size() == 0) begin
          $error("result beat with no prediction pending");
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          check_field("coil_on", SampleW'(want.coil_on), SampleW'(out_if.coil_on));
          check_field("relay_on", SampleW'(want.relay_on), SampleW'(out_if.relay_on));
          check_field("capture_start", SampleW'(want.capture_start),
                      SampleW'(out_if.capture_start));
          check_field("capture_length", want.capture_length, out_if.capture_length);
          check_field("scan_advance", SampleW'(want.scan_advance),
                      SampleW'(out_if.scan_advance));
          check_field("buffer_clear", SampleW'(want.buffer_clear),
                      SampleW'(out_if.buffer_clear));
          check_field("busy_res", SampleW'(want.busy_res), SampleW'(out_if.busy_res));
          check_field("scans_left", SampleW'(want.scans_left), SampleW'(out_if.scans_left));
        end
      end
      pat_age++;
      if (pat_age % 48 == 0) begin
        stall_pat = ($urandom_range(0, 2) == 0) ? 8'h00 : (8'($urandom) & 8'h7F);
      end else begin
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      out_if.ready <= !stall_pat[0];
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    // everything known from time zero; predictor matches reset state
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = '0;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_TICK;
    in_if.scan_request = '0;
    out_if.ready       = 1'b0;
    coil_ms            = '0;
    rec_ms             = '0;
    pre_ms             = '0;
    post_ms            = '0;
    cap_len            = '0;
    seq_phase          = S_IDLE;
    tick_cnt           = '0;
    scans_open         = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset timing (all zero). Idle-state no-ops, zero-scan start, then one
    // scan that drops straight into capture, with a busy start, a stray tick
    // and an unused opcode while capturing.
    @(negedge clk_i);
    issue(OP_UNUSED, ScanW'($urandom));
    issue(OP_TICK, '1);
    issue(OP_CAPDONE, '0);
    issue(OP_START, '0);
    issue(OP_START, ScanW'(1));
    issue(OP_START, '1);
    issue(OP_TICK, ScanW'($urandom));
    issue(OP_UNUSED, '1);
    issue(OP_CAPDONE, ScanW'($urandom));
    settle();

    // Writes past the last register must change nothing: the next capture
    // still asks for zero samples.
    for (int i = REG_SAMPLES + 1; i < 2**CfgIdxW; i++) write_reg(CfgIdxW'(i), '1);
    @(negedge clk_i);
    issue(OP_START, ScanW'(1));
    issue(OP_CAPDONE, '0);
    settle();

    // No recovery: each capture done retires a scan and, while scans remain,
    // starts the next capture in the same beat. Full sample count.
    program_timing('0, '0, '0, '0, '1);
    @(negedge clk_i);
    issue(OP_START, ScanW'(3));
    repeat (3) issue(OP_CAPDONE, ScanW'($urandom));
    settle();

    // Shortest nonzero delays, two scans.
    program_timing(PulseW'(1), RecW'(1), PreW'(1), PostW'(1), SampleW'($urandom));
    run_scans(ScanW'(2));

    // Longer delays, one scan.
    program_timing(PulseW'(60), RecW'(50), PreW'(40), PostW'(30), SampleW'($urandom));
    run_scans(ScanW'(1));

    // Long run of scans with zero delays.
    program_timing('0, '0, '0, '0, SampleW'($urandom));
    run_scans(ScanW'(100));

    // Random part: several small-delay settings, well-formed runs with noise.
    for (int r = 0; r < 4; r++) begin
      program_timing(PulseW'($urandom_range(0, 3)), RecW'($urandom_range(0, 3)),
                     PreW'($urandom_range(0, 3)), PostW'($urandom_range(0, 3)),
                     SampleW'($urandom));
      feed_random(120);
    end

    settle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hang guard: well past the slowest legal run.
  initial begin
    #(RunLimitNs);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
